// File: rtl/fbm_value_noise_shader_defines.svh
// assertion macros used by the checker
`ifndef FBM_VALUE_NOISE_SHADER_DEFINES_SVH
`define FBM_VALUE_NOISE_SHADER_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define FVN_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication whose consequent is checked in the next cycle
`define FVN_CHECK_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) cond |=> prop) else $error(msg);

`endif

// File: rtl/fvn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fvn_pkg;

  localparam int OCTAVES    = 6;
  localparam int COORD_BITS = 12;

  localparam int CRD_W  = 24;               // Q8.16 coordinate
  localparam int FRAC_W = 16;
  localparam int NUM_W  = COORD_BITS + 2 + FRAC_W;
  localparam int DEN_W  = 13;
  localparam int OUT_W  = 16;
  localparam int ACC_W  = OUT_W + OCTAVES;
  localparam int DIV_STEPS  = NUM_W;
  localparam int CELL_DEPTH = 14;

  localparam logic [31:0] KX_TURN  = 32'd289441625;
  localparam logic [31:0] KY_TURN  = 32'd1937754653;
  localparam logic [15:0] SIN_A    = 16'd51472;
  localparam logic [14:0] SIN_B    = 15'd21024;
  localparam logic [11:0] SIN_C    = 12'd2320;
  localparam logic [31:0] HASH_MUL = 32'd2867760026;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef struct packed {
    logic [DEN_W-1:0] rem_x;
    logic [NUM_W-1:0] num_x;
    logic [DEN_W-1:0] rem_y;
    logic [NUM_W-1:0] num_y;
  } div_t;

  typedef struct packed {
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic [ACC_W-1:0] acc;
  } lane_t;

endpackage
`default_nettype wire

// File: rtl/fvn_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module fvn_div_cell import fvn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [DEN_W-1:0] den,
  input  logic             in_valid,
  input  div_t             in_data,
  output logic             out_valid,
  output div_t             out_data
);

  logic [DEN_W:0] cand_x, cand_y, diff_x, diff_y;
  logic           ge_x, ge_y;

  // one restoring step per lane: shift in the next numerator bit
  always_comb begin
    cand_x = {in_data.rem_x, in_data.num_x[NUM_W-1]};
    cand_y = {in_data.rem_y, in_data.num_y[NUM_W-1]};
    ge_x   = cand_x >= {1'b0, den};
    ge_y   = cand_y >= {1'b0, den};
    diff_x = ge_x ? cand_x - {1'b0, den} : cand_x;
    diff_y = ge_y ? cand_y - {1'b0, den} : cand_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.rem_x <= diff_x[DEN_W-1:0];
      out_data.num_x <= {in_data.num_x[NUM_W-2:0], ge_x};
      out_data.rem_y <= diff_y[DEN_W-1:0];
      out_data.num_y <= {in_data.num_y[NUM_W-2:0], ge_y};
    end
  end

endmodule
`default_nettype wire

// File: rtl/fvn_octave_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module fvn_octave_cell import fvn_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  lane_t in_lane,
  output logic  out_valid,
  output lane_t out_lane
);

  logic [CELL_DEPTH-2:0] vl;
  lane_t side [CELL_DEPTH-1];

  logic [31:0] mx0, my0;
  logic [15:0] fx, fy, f2x, f2y;
  logic [31:0] ph [4];
  logic [16:0] uxl [8];
  logic [16:0] uyl [10];
  logic [14:0] z3 [4];
  logic        n3 [4];
  logic [14:0] z4 [4], z2_4 [4];
  logic        n4 [4];
  logic [14:0] t2_5 [4], z2_5 [4], z5 [4];
  logic        n5 [4];
  logic [15:0] t4_6 [4];
  logic [14:0] z6 [4];
  logic        n6 [4];
  logic [16:0] mag7 [4];
  logic        n7 [4];
  logic [30:0] pr8 [4];
  logic        n8 [4];
  logic [15:0] h9 [4];
  logic [32:0] pa, pb, pc, pd;
  logic [15:0] r0, r1;
  logic [32:0] q0, q1;
  logic [15:0] nz;

  // combinational terms
  logic [17:0] wx, wy;
  logic [33:0] sx, sy;
  logic [15:0] p_c [4];
  logic [14:0] z_c [4];
  logic [29:0] zz [4];
  logic [26:0] ct [4];
  logic [29:0] zt [4];
  logic [30:0] zm [4];
  logic [30:0] pm [4];
  logic [30:0] ng [4];
  logic [16:0] omx, omy;
  logic [33:0] sum0, sum1, sumn;

  always_comb begin
    wx = 18'd196608 - {1'b0, fx, 1'b0};
    wy = 18'd196608 - {1'b0, fy, 1'b0};
    sx = 34'(f2x) * 34'(wx);
    sy = 34'(f2y) * 34'(wy);
    for (int j = 0; j < 4; j++) begin
      p_c[j] = ph[j][31:16];
      // fold the phase into a quarter wave
      z_c[j] = p_c[j][14] ? 15'h4000 - {1'b0, p_c[j][13:0]} : {1'b0, p_c[j][13:0]};
      zz[j]  = 30'(z3[j]) * 30'(z3[j]);
      ct[j]  = 27'(SIN_C) * 27'(z2_4[j]);
      zt[j]  = 30'(z2_5[j]) * 30'(t2_5[j]);
      zm[j]  = 31'(z6[j]) * 31'(t4_6[j]);
      pm[j]  = 31'(mag7[j]) * 31'(HASH_MUL);
      ng[j]  = 31'd0 - pr8[j];
    end
    omx  = 17'd65536 - uxl[7];
    omy  = 17'd65536 - uyl[9];
    sum0 = {1'b0, pa} + {1'b0, pb};
    sum1 = {1'b0, pc} + {1'b0, pd};
    sumn = {1'b0, q0} + {1'b0, q1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vl        <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vl        <= {vl[CELL_DEPTH-3:0], in_valid};
      out_valid <= vl[CELL_DEPTH-2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_lane;
      for (int k = 1; k < CELL_DEPTH - 1; k++) side[k] <= side[k-1];

      // lattice phases and smoothstep square
      mx0 <= {24'd0, in_lane.x[CRD_W-1:FRAC_W]} * KX_TURN;
      my0 <= {24'd0, in_lane.y[CRD_W-1:FRAC_W]} * KY_TURN;
      fx  <= in_lane.x[FRAC_W-1:0];
      fy  <= in_lane.y[FRAC_W-1:0];
      f2x <= 16'((32'(in_lane.x[FRAC_W-1:0]) * 32'(in_lane.x[FRAC_W-1:0])) >> 16);
      f2y <= 16'((32'(in_lane.y[FRAC_W-1:0]) * 32'(in_lane.y[FRAC_W-1:0])) >> 16);

      ph[0]  <= mx0 + my0;
      ph[1]  <= mx0 + KX_TURN + my0;
      ph[2]  <= mx0 + my0 + KY_TURN;
      ph[3]  <= mx0 + KX_TURN + my0 + KY_TURN;
      uxl[0] <= sx[32:16];
      uyl[0] <= sy[32:16];
      for (int k = 1; k < 8; k++) uxl[k] <= uxl[k-1];
      for (int k = 1; k < 10; k++) uyl[k] <= uyl[k-1];

      for (int j = 0; j < 4; j++) begin
        z3[j]   <= z_c[j];
        n3[j]   <= p_c[j][15];
        z4[j]   <= z3[j];
        z2_4[j] <= zz[j][28:14];
        n4[j]   <= n3[j];
        t2_5[j] <= SIN_B - {2'b0, ct[j][26:14]};
        z2_5[j] <= z2_4[j];
        z5[j]   <= z4[j];
        n5[j]   <= n4[j];
        t4_6[j] <= SIN_A - zt[j][29:14];
        z6[j]   <= z5[j];
        n6[j]   <= n5[j];
        mag7[j] <= zm[j][30:14];
        n7[j]   <= n6[j];
        pr8[j]  <= pm[j];
        n8[j]   <= n7[j];
        // fraction of the hash product, negative half turn negated
        h9[j]   <= n8[j] ? ng[j][30:15] : pr8[j][30:15];
      end

      pa <= 33'(h9[0]) * 33'(omx);
      pb <= 33'(h9[1]) * 33'(uxl[7]);
      pc <= 33'(h9[2]) * 33'(omx);
      pd <= 33'(h9[3]) * 33'(uxl[7]);
      r0 <= sum0[31:16];
      r1 <= sum1[31:16];
      q0 <= 33'(r0) * 33'(omy);
      q1 <= 33'(r1) * 33'(uyl[9]);
      nz <= sumn[31:16];

      // next octave doubles the coordinate, horner step on the sum
      out_lane.x   <= {side[CELL_DEPTH-2].x[CRD_W-2:0], 1'b0};
      out_lane.y   <= {side[CELL_DEPTH-2].y[CRD_W-2:0], 1'b0};
      out_lane.acc <= {side[CELL_DEPTH-2].acc[ACC_W-2:0], 1'b0} + ACC_W'(nz);
    end
  end

endmodule
`default_nettype wire

// File: rtl/fbm_value_noise_shader.sv
`timescale 1ns / 1ps
`default_nettype none
// Fractal value noise shader: one pixel coordinate in, one unsigned Q0.16 grey
// level out, one transaction per clock sustained while grey_stall is low. The
// coordinate passes a chain of 30 restoring divider cells (one quotient bit each,
// 3 * pixel * 65536 / height on both axes) and then one octave cell per octave,
// 14 stages each; every cell takes a new item each cycle unless the chain is
// stalled. A two-entry output queue holds finished results while grey_stall is
// high, and pixel_stall rises only once that queue is full. frame_width is accepted
// but has no effect, since it cancels out of the aspect correction; a frame
// height of zero acts as one. Write the registers only while the block is empty.
module fbm_value_noise_shader import fvn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [DEN_W-1:0]      cfg_data,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  output logic                  grey_valid,
  input  logic                  grey_stall,
  output logic [OUT_W-1:0]      grey_level
);

  logic [DEN_W-1:0] frame_height;
  logic [DEN_W-1:0] den;
  logic             en;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_height <= DEN_W'(1080);
    end else if (cfg_write && cfg_index == REG_FRAME_HEIGHT) begin
      frame_height <= cfg_data;
    end
  end

  assign den = (frame_height == '0) ? DEN_W'(1) : frame_height;

  logic [COORD_BITS+1:0] tx, ty;
  div_t                  div_d [DIV_STEPS+1];
  logic                  div_v [DIV_STEPS+1];

  assign tx = {1'b0, pixel_x, 1'b0} + {2'b0, pixel_x};
  assign ty = {1'b0, pixel_y, 1'b0} + {2'b0, pixel_y};
  assign div_v[0]       = pixel_valid;
  assign div_d[0].rem_x = '0;
  assign div_d[0].num_x = {tx, {FRAC_W{1'b0}}};
  assign div_d[0].rem_y = '0;
  assign div_d[0].num_y = {ty, {FRAC_W{1'b0}}};

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    fvn_div_cell u_div (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .den      (den),
      .in_valid (div_v[i]),
      .in_data  (div_d[i]),
      .out_valid(div_v[i+1]),
      .out_data (div_d[i+1])
    );
  end

  lane_t oct_d [OCTAVES+1];
  logic  oct_v [OCTAVES+1];

  assign oct_v[0]     = div_v[DIV_STEPS];
  assign oct_d[0].x   = div_d[DIV_STEPS].num_x[CRD_W-1:0];
  assign oct_d[0].y   = div_d[DIV_STEPS].num_y[CRD_W-1:0];
  assign oct_d[0].acc = '0;

  for (genvar k = 0; k < OCTAVES; k++) begin : g_oct
    fvn_octave_cell u_oct (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (oct_v[k]),
      .in_lane  (oct_d[k]),
      .out_valid(oct_v[k+1]),
      .out_lane (oct_d[k+1])
    );
  end

  // output queue
  logic [OUT_W-1:0] q_mem [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count, count_next;
  logic             push, pop;

  assign en          = (count != 2'd2);
  assign pixel_stall = !en;
  assign push        = en && oct_v[OCTAVES];
  assign pop         = grey_valid && !grey_stall;
  assign grey_valid  = (count != 2'd0);
  assign grey_level  = q_mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + 2'd1;
    else if (pop && !push) count_next = count - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= oct_d[OCTAVES].acc[ACC_W-1:OCTAVES];
  end

endmodule
`default_nettype wire

// File: rtl/fvn_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "fbm_value_noise_shader_defines.svh"
module fvn_checker import fvn_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             pixel_stall,
  input logic             grey_valid,
  input logic             grey_stall,
  input logic [OUT_W-1:0] grey_level
);

  `FVN_CHECK_NEXT(a_out_hold, grey_valid && grey_stall, grey_valid && $stable(grey_level), "stalled result changed")
  `FVN_CHECK(a_reset_empty, $past(rst) |-> !grey_valid, "result right after reset")
  `FVN_CHECK(a_stall_cause, pixel_stall |-> $past(grey_valid && grey_stall), "input stalled without backpressure")
  `FVN_CHECK(a_empty_open, !grey_valid |-> !pixel_stall, "input stalled with empty queue")

endmodule

bind fbm_value_noise_shader fvn_checker u_chk (.*);
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import fvn_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 130;

  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } pixel_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [1:0]            cfg_index;
  logic [DEN_W-1:0]      cfg_data;
  logic                  pixel_valid;
  logic                  pixel_stall;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  grey_valid;
  logic                  grey_stall;
  logic [OUT_W-1:0]      grey_level;

  pixel_t          pixel_fifo[$];
  logic [OUT_W-1:0] grey_expected[$];
  logic [63:0]     shade_width;
  logic [63:0]     shade_height;
  int              mismatches;
  int              issued_cnt;
  int              accepted_cnt;
  int              idle_cycles;
  bit              px_taken;
  bit              grey_taken;
  bit              burst_mode;
  bit              hold_req;
  bit              hold_used;
  int              hold_cnt;
  int              tx_gap;
  int              rx_wait;

  fbm_value_noise_shader uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .grey_valid(grey_valid), .grey_stall(grey_stall), .grey_level(grey_level)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // corner hash: sine of the lattice phase times the big constant, fraction bits
  function automatic logic [63:0] corner_hash(logic [31:0] ix, logic [31:0] iy);
    logic [31:0] phase;
    logic [15:0] p;
    logic [1:0]  quad;
    logic [63:0] z, z2, t1, t2, t3, t4, mag, prod;
    phase = ix * KX_TURN + iy * KY_TURN;
    p = phase[31:16];
    quad = p[15:14];
    z = quad[0] ? 64'(16'h4000 - {2'b00, p[13:0]}) : 64'(p[13:0]);
    z2 = (z * z) >> 14;
    t1 = (64'(SIN_C) * z2) >> 14;
    t2 = 64'(SIN_B) - t1;
    t3 = (z2 * t2) >> 14;
    t4 = 64'(SIN_A) - t3;
    mag = (z * t4) >> 14;
    prod = mag * 64'(HASH_MUL);
    if (quad[1]) prod = 64'd0 - prod;
    return 64'(prod[30:15]);
  endfunction

  function automatic logic [63:0] smooth_weight(logic [63:0] f);
    logic [63:0] f2;
    f2 = (f * f) >> 16;
    return (f2 * (64'd196608 - 2 * f)) >> 16;
  endfunction

  function automatic logic [63:0] mix_q16(logic [63:0] a, logic [63:0] b, logic [63:0] u);
    return (a * (64'd65536 - u) + b * u) >> 16;
  endfunction

  function automatic logic [63:0] lattice_noise(logic [63:0] x, logic [63:0] y);
    logic [31:0] ix, iy;
    logic [63:0] ux, uy, top, bot;
    ix = 32'(x >> 16);
    iy = 32'(y >> 16);
    ux = smooth_weight(x & 64'hFFFF);
    uy = smooth_weight(y & 64'hFFFF);
    top = mix_q16(corner_hash(ix, iy), corner_hash(ix + 1, iy), ux);
    bot = mix_q16(corner_hash(ix, iy + 1), corner_hash(ix + 1, iy + 1), ux);
    return mix_q16(top, bot, uy);
  endfunction

  function automatic logic [OUT_W-1:0] fbm_grey(logic [COORD_BITS-1:0] px,
                                               logic [COORD_BITS-1:0] py);
    logic [63:0] h, x0, y0, sum;
    h = (shade_height == 0) ? 64'd1 : shade_height;
    x0 = ((64'd3 * px) << 16) / h;
    y0 = ((64'd3 * py) << 16) / h;
    x0 &= 64'hFFFFFF;
    y0 &= 64'hFFFFFF;
    sum = 0;
    for (int k = 0; k < OCTAVES; k++)
      sum += lattice_noise((x0 << k) & 64'hFFFFFF, (y0 << k) & 64'hFFFFFF)
             << (OCTAVES - 1 - k);
    sum >>= OCTAVES;
    if (sum > 64'hFFFF) sum = 64'hFFFF;
    return sum[OUT_W-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // input side: acceptance, prediction
  always @(posedge clk) begin
    if (rst) begin
      px_taken <= 1'b0;
    end else begin
      px_taken <= pixel_valid && !pixel_stall;
      if (pixel_valid && !pixel_stall) begin
        grey_expected.push_back(fbm_grey(pixel_x, pixel_y));
        accepted_cnt++;
      end
    end
  end

  // output side: check against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      grey_taken <= 1'b0;
    end else begin
      grey_taken <= grey_valid && !grey_stall;
      if (grey_valid && !grey_stall) begin
        if (grey_expected.size() == 0)
          report_mismatch("unexpected transaction", grey_level, '0);
        else if (grey_level !== grey_expected[0])
          report_mismatch("grey_level", grey_level, grey_expected.pop_front());
        else
          void'(grey_expected.pop_front());
      end
    end
  end

  // pixel driver
  always @(negedge clk) begin
    logic next_valid;
    pixel_t item;
    next_valid = 1'b0;
    if (!rst) begin
      if (pixel_valid && !px_taken) begin
        next_valid = 1'b1;
      end else if (tx_gap > 0) begin
        tx_gap--;
      end else if (pixel_fifo.size() > 0) begin
        item = pixel_fifo.pop_front();
        pixel_x <= item.x;
        pixel_y <= item.y;
        next_valid = 1'b1;
        tx_gap = burst_mode ? 0 : $urandom_range(0, 4);
      end
    end
    pixel_valid <= next_valid;
  end

  // grey receiver, with one long hold-off on request
  always @(negedge clk) begin
    logic next_stall;
    next_stall = 1'b0;
    if (!rst) begin
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_cnt = 400;
      end
      if (grey_taken) rx_wait = burst_mode ? 0 : $urandom_range(0, 4);
      if (hold_cnt > 0) begin
        hold_cnt--;
        next_stall = 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        next_stall = 1'b1;
      end
    end
    grey_stall <= next_stall;
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (grey_valid && !grey_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [DEN_W-1:0] value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == REG_FRAME_WIDTH) shade_width = 64'(value);
    else if (idx == REG_FRAME_HEIGHT) shade_height = 64'(value);
  endtask

  task automatic queue_pixel(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
    pixel_t item;
    item.x = x;
    item.y = y;
    pixel_fifo.push_back(item);
    issued_cnt++;
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) begin
      // mostly the full range, some near the edges
      case ($urandom_range(0, 5))
        0: queue_pixel(COORD_BITS'($urandom_range(0, 15)), COORD_BITS'($urandom));
        1: queue_pixel(COORD_BITS'($urandom), COORD_BITS'(4095 - $urandom_range(0, 15)));
        default: queue_pixel(COORD_BITS'($urandom), COORD_BITS'($urandom));
      endcase
    end
  endtask

  task automatic wait_drained();
    while (accepted_cnt < issued_cnt || grey_expected.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pixel_valid = 1'b0;
    pixel_x = '0;
    pixel_y = '0;
    grey_stall = 1'b0;
    mismatches = 0;
    issued_cnt = 0;
    accepted_cnt = 0;
    idle_cycles = 0;
    tx_gap = 0;
    rx_wait = 0;
    hold_cnt = 0;
    hold_req = 1'b0;
    hold_used = 1'b0;
    burst_mode = 1'b0;
    shade_width = 64'd1920;
    shade_height = 64'd1080;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset values, field extremes
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(4095, 0);
    queue_pixel(0, 4095);
    queue_pixel(1, 1);
    queue_pixel(2048, 2048);
    queue_pixel(1079, 1919);
    queue_pixel(12'hAAA, 12'h555);
    queue_random(150);
    wait_drained();

    // zero height acts as one; unused indexes ignored
    write_reg(REG_FRAME_WIDTH, 13'd0);
    write_reg(REG_FRAME_HEIGHT, 13'd0);
    write_reg(2'd2, 13'h1FFF);
    write_reg(2'd3, 13'd5);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(1, 2);
    queue_random(150);
    wait_drained();

    // height 1, full throughput burst with the long hold-off
    write_reg(REG_FRAME_HEIGHT, 13'd1);
    write_reg(REG_FRAME_WIDTH, 13'd8191);
    burst_mode = 1'b1;
    hold_req = 1'b1;
    queue_random(300);
    wait_drained();
    burst_mode = 1'b0;

    write_reg(REG_FRAME_HEIGHT, 13'd4096);
    write_reg(REG_FRAME_WIDTH, 13'd4096);
    queue_pixel(4095, 4095);
    queue_random(150);
    wait_drained();

    write_reg(REG_FRAME_HEIGHT, 13'd8191);
    queue_pixel(4095, 0);
    queue_random(120);
    wait_drained();

    write_reg(REG_FRAME_HEIGHT, 13'd7);
    write_reg(REG_FRAME_WIDTH, 13'd1);
    queue_random(150);
    wait_drained();

    for (int p = 0; p < 3; p++) begin
      write_reg(REG_FRAME_HEIGHT, DEN_W'($urandom_range(1, 4096)));
      write_reg(REG_FRAME_WIDTH, DEN_W'($urandom));
      queue_random(130);
      wait_drained();
    end

    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
